[design/mrac_pkg.sv]
package mrac_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_REGION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ENTRY_MARKER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END       = 3'd5;

    localparam logic [31:0] WINDOW_START_RST = 32'h000f_4000;
    localparam logic [31:0] WINDOW_END_RST   = 32'h000f_e000;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_HEADER = 2'd2;
    localparam logic [1:0] ST_IMAGE  = 2'd3;

    typedef struct packed {
        logic [31:0] expected_magic;
        logic [31:0] expected_version;
        logic [31:0] expected_region;
        logic [31:0] no_entry_marker;
        logic [31:0] window_start;
        logic [31:0] window_end;
    } t_cfg;

    typedef struct packed {
        logic [31:0] hdr_magic;
        logic [31:0] hdr_version;
        logic [31:0] hdr_region;
        logic [31:0] load_base;
        logic [31:0] image_bytes;
        logic [31:0] footprint_bytes;
        logic [31:0] init_entry_offset;
        logic [31:0] update_entry_offset;
    } t_hdr;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
    } t_region;

endpackage

[design/mrac_region_mem.sv]
module mrac_region_mem #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  mrac_pkg::t_region    i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output mrac_pkg::t_region    o_rd_data
);

    mrac_pkg::t_region r_mem [DEPTH];
    mrac_pkg::t_region r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mrac_hdr_check.sv]
module mrac_hdr_check (
    input  mrac_pkg::t_cfg  i_cfg,
    input  mrac_pkg::t_hdr  i_hdr,
    output logic            o_hdr_ok
);

    logic id_ok;
    logic base_ok;
    logic size_ok;
    logic room_ok;
    logic init_ok;
    logic upd_ok;
    logic [31:0] room;

    function automatic logic offset_ok(input logic [31:0] off, input logic [31:0] img,
                                       input logic [31:0] marker);
        return (off == marker) || ((off[1:0] == 2'b00) && (off < img));
    endfunction

    always_comb begin
        id_ok = (i_hdr.hdr_magic == i_cfg.expected_magic)
             && (i_hdr.hdr_version == i_cfg.expected_version)
             && ((i_hdr.hdr_region == 32'd0)
                 || (i_hdr.hdr_region == i_cfg.expected_region));

        // an inverted window fails here for every base
        base_ok = (i_hdr.load_base[3:0] == 4'd0)
               && (i_hdr.load_base >= i_cfg.window_start)
               && (i_hdr.load_base < i_cfg.window_end);

        size_ok = (i_hdr.image_bytes != 32'd0)
               && (i_hdr.image_bytes[1:0] == 2'b00)
               && (i_hdr.image_bytes <= i_hdr.footprint_bytes);

        // only meaningful once base_ok holds, which guards the wrap
        room    = i_cfg.window_end - i_hdr.load_base;
        room_ok = (i_hdr.footprint_bytes <= room);

        init_ok = offset_ok(i_hdr.init_entry_offset, i_hdr.image_bytes,
                            i_cfg.no_entry_marker);
        upd_ok  = offset_ok(i_hdr.update_entry_offset, i_hdr.image_bytes,
                            i_cfg.no_entry_marker);

        o_hdr_ok = id_ok && base_ok && size_ok && room_ok && init_ok && upd_ok;
    end

endmodule

[design/module_region_admission_check.sv]
// Module region admission check. One header is taken at a time; the block
// stalls its input from acceptance until the result is placed in the output
// register, while a previous result may still wait there. An accepted header
// passes a check state, then a scan state and a done state that loads the
// output register. The stored regions sit in one memory with a registered
// read and the overlap scan reads one entry per cycle, so the scan grows with
// the number of stored regions; a full table is refused before the scan, so
// at most MAX_REGIONS - 1 regions are scanned. Items that fail the table-full
// or header checks skip the scan. A stalled output holds the result back and
// delays the next transfer as well.
// Configuration is written through the cfg port only while the block is idle,
// a rule for the user that the block itself does not enforce; index values
// beyond the register list are ignored.
module module_region_admission_check #(
    parameter int unsigned MAX_REGIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_hdr_magic,
    input  logic [31:0] i_hdr_version,
    input  logic [31:0] i_hdr_region,
    input  logic [31:0] i_load_base,
    input  logic [31:0] i_image_bytes,
    input  logic [31:0] i_footprint_bytes,
    input  logic [31:0] i_init_entry_offset,
    input  logic [31:0] i_update_entry_offset,
    input  logic        i_image_ok,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [3:0]  o_entries_used
);

    localparam int unsigned CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int unsigned IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CEXT_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int unsigned SEXT_W = (IDX_W > 3) ? IDX_W : 3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    mrac_pkg::t_cfg     r_cfg;
    mrac_pkg::t_hdr     r_hdr;
    logic               r_image_ok;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic               r_ovl;
    logic [1:0]         r_res_status;
    logic [1:0]         n_res_status;
    logic [32:0]        r_new_end;

    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [2:0]         r_out_slot;
    logic [3:0]         r_out_count;

    logic               hdr_ok;
    logic               in_xfer;
    logic               out_free;
    logic               finish;
    logic               admit;
    logic               rd_en;
    logic               ovl_hit;
    logic               scan_end;
    logic [32:0]        old_end;
    logic [CNT_W-1:0]   count_after;
    logic [CEXT_W-1:0]  count_ext;
    logic [SEXT_W-1:0]  slot_ext;
    mrac_pkg::t_region  wr_data;
    mrac_pkg::t_region  rd_data;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_magic   <= 32'd0;
            r_cfg.expected_version <= 32'd0;
            r_cfg.expected_region  <= 32'd0;
            r_cfg.no_entry_marker  <= 32'd0;
            r_cfg.window_start     <= mrac_pkg::WINDOW_START_RST;
            r_cfg.window_end       <= mrac_pkg::WINDOW_END_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mrac_pkg::CFG_EXPECTED_MAGIC:   r_cfg.expected_magic   <= i_cfg_data;
                mrac_pkg::CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data;
                mrac_pkg::CFG_EXPECTED_REGION:  r_cfg.expected_region  <= i_cfg_data;
                mrac_pkg::CFG_NO_ENTRY_MARKER:  r_cfg.no_entry_marker  <= i_cfg_data;
                mrac_pkg::CFG_WINDOW_START:     r_cfg.window_start     <= i_cfg_data;
                mrac_pkg::CFG_WINDOW_END:       r_cfg.window_end       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- input capture ----------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_hdr.hdr_magic           <= i_hdr_magic;
            r_hdr.hdr_version         <= i_hdr_version;
            r_hdr.hdr_region          <= i_hdr_region;
            r_hdr.load_base           <= i_load_base;
            r_hdr.image_bytes         <= i_image_bytes;
            r_hdr.footprint_bytes     <= i_footprint_bytes;
            r_hdr.init_entry_offset   <= i_init_entry_offset;
            r_hdr.update_entry_offset <= i_update_entry_offset;
            r_image_ok                <= i_image_ok;
        end
    end

    mrac_hdr_check u_hdr_check (
        .i_cfg    (r_cfg),
        .i_hdr    (r_hdr),
        .o_hdr_ok (hdr_ok)
    );

    // ---------------- region store ----------------
    assign rd_en   = (r_state == S_SCAN) && (r_idx < r_count);
    assign admit   = finish && (r_res_status == mrac_pkg::ST_OK);
    assign wr_data = '{base: r_hdr.load_base, length: r_hdr.footprint_bytes};

    // writes land only at the end of an item, and the idle and check states lie
    // between a write and the next scan, so a read never meets a write to the same entry
    mrac_region_mem #(
        .DEPTH (MAX_REGIONS),
        .AW    (IDX_W)
    ) u_region_mem (
        .i_clk     (i_clk),
        .i_wr_en   (admit),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // half-open overlap test, no wrap
    assign old_end  = {1'b0, rd_data.base} + {1'b0, rd_data.length};
    assign ovl_hit  = r_pend && ({1'b0, r_hdr.load_base} < old_end)
                             && ({1'b0, rd_data.base} < r_new_end);
    assign scan_end = (r_idx == r_count) && !r_pend;

    // ---------------- sequencer ----------------
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_count >= CNT_MAX) begin
                    n_res_status = mrac_pkg::ST_FULL;
                    n_state      = S_DONE;
                end else if (!hdr_ok) begin
                    n_res_status = mrac_pkg::ST_HEADER;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                    if (r_ovl) begin
                        n_res_status = mrac_pkg::ST_HEADER;
                    end else if (!r_image_ok) begin
                        n_res_status = mrac_pkg::ST_IMAGE;
                    end else begin
                        n_res_status = mrac_pkg::ST_OK;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_ovl        <= 1'b0;
            r_res_status <= mrac_pkg::ST_OK;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            if (r_state == S_CHECK) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_ovl  <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (ovl_hit) begin
                    r_ovl <= 1'b1;
                end
            end else begin
                r_pend <= 1'b0;
            end
            if (admit) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_new_end <= {1'b0, r_hdr.load_base} + {1'b0, r_hdr.footprint_bytes};
        end
    end

    // ---------------- output register ----------------
    assign count_after = admit ? (r_count + 1'b1) : r_count;
    assign count_ext   = CEXT_W'(count_after);
    assign slot_ext    = admit ? SEXT_W'(r_count[IDX_W-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_status <= r_res_status;
            r_out_slot   <= slot_ext[2:0];
            r_out_count  <= count_ext[3:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_entries_used = r_out_count;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("region count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 1'b1) && $past(admit))
        else $error("region count changed without an admission");

    a_admit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        admit |-> (r_count < CNT_MAX) && !r_ovl && r_image_ok)
        else $error("store write for a refused header");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != mrac_pkg::ST_OK) |-> (o_slot == 3'd0))
        else $error("slot set on a refused header");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("store read pending outside the scan");

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REGIONS = 8;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned ITEMS_PER_SETTING = 210;
    // indexes past the register list; writes to them must be ignored
    localparam logic [mrac_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [mrac_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        mrac_pkg::t_hdr hdr;
        logic image_ok;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [3:0] entries_used;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_hdr_magic;
    logic [31:0] i_hdr_version;
    logic [31:0] i_hdr_region;
    logic [31:0] i_load_base;
    logic [31:0] i_image_bytes;
    logic [31:0] i_footprint_bytes;
    logic [31:0] i_init_entry_offset;
    logic [31:0] i_update_entry_offset;
    logic        i_image_ok;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [2:0]  o_slot;
    logic [3:0]  o_entries_used;

    // predictor state
    mrac_pkg::t_cfg cfg_model;
    logic [31:0] stored_base [MAX_REGIONS];
    logic [31:0] stored_len  [MAX_REGIONS];
    int unsigned stored_n;

    t_verdict    pending_verdicts [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned recv_hold_cycles = 0;

    module_region_admission_check #(
        .MAX_REGIONS(MAX_REGIONS)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_hdr_magic          (i_hdr_magic),
        .i_hdr_version        (i_hdr_version),
        .i_hdr_region         (i_hdr_region),
        .i_load_base          (i_load_base),
        .i_image_bytes        (i_image_bytes),
        .i_footprint_bytes    (i_footprint_bytes),
        .i_init_entry_offset  (i_init_entry_offset),
        .i_update_entry_offset(i_update_entry_offset),
        .i_image_ok           (i_image_ok),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_slot               (o_slot),
        .o_entries_used       (o_entries_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit offset_allowed(logic [31:0] off, logic [31:0] img);
        return off == cfg_model.no_entry_marker || (off[1:0] == 2'b00 && off < img);
    endfunction

    function automatic bit header_fits(mrac_pkg::t_hdr h);
        logic [32:0] sb, se, nb, ne;
        if (h.hdr_magic != cfg_model.expected_magic) return 1'b0;
        if (h.hdr_version != cfg_model.expected_version) return 1'b0;
        if (h.hdr_region != 32'd0 && h.hdr_region != cfg_model.expected_region) return 1'b0;
        if (h.load_base[3:0] != 4'd0 || h.load_base < cfg_model.window_start ||
            h.load_base >= cfg_model.window_end) return 1'b0;
        if (h.image_bytes == 32'd0 || h.image_bytes[1:0] != 2'b00 ||
            h.image_bytes > h.footprint_bytes) return 1'b0;
        // base is below window_end here, so the room never wraps
        if (h.footprint_bytes > cfg_model.window_end - h.load_base) return 1'b0;
        if (!offset_allowed(h.init_entry_offset, h.image_bytes) ||
            !offset_allowed(h.update_entry_offset, h.image_bytes)) return 1'b0;
        nb = {1'b0, h.load_base};
        ne = nb + {1'b0, h.footprint_bytes};
        for (int i = 0; i < stored_n; i++) begin
            sb = {1'b0, stored_base[i]};
            se = sb + {1'b0, stored_len[i]};
            if (nb < se && sb < ne) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_verdict admission_verdict(t_req r);
        t_verdict v;
        v.slot = 3'd0;
        if (stored_n >= MAX_REGIONS) begin
            v.status = mrac_pkg::ST_FULL;
        end else if (!header_fits(r.hdr)) begin
            v.status = mrac_pkg::ST_HEADER;
        end else if (!r.image_ok) begin
            v.status = mrac_pkg::ST_IMAGE;
        end else begin
            v.slot = 3'(stored_n);
            stored_base[stored_n] = r.hdr.load_base;
            stored_len[stored_n] = r.hdr.footprint_bytes;
            stored_n++;
            v.status = mrac_pkg::ST_OK;
        end
        v.entries_used = 4'(stored_n);
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus shaping

    function automatic logic [31:0] entry_offset(logic [31:0] img);
        case ($urandom_range(0, 3))
            0: return cfg_model.no_entry_marker;
            1: return 32'd0;
            2: return img - 32'd4;
            default: return 32'($urandom_range(0, (img >> 2) - 1)) << 2;
        endcase
    endfunction

    // A header shaped for the current setting: identity fields always match; the
    // window, size and overlap checks may still fail, depending on where the base lands.
    function automatic mrac_pkg::t_hdr shaped_header();
        mrac_pkg::t_hdr h;
        logic [32:0] lo, hi;
        logic [31:0] room, cap;
        int unsigned pick, idx;
        h.hdr_magic = cfg_model.expected_magic;
        h.hdr_version = cfg_model.expected_version;
        h.hdr_region = $urandom_range(0, 1) ? 32'd0 : cfg_model.expected_region;
        lo = ({1'b0, cfg_model.window_start} + 33'd15) & ~33'hf;
        hi = ({1'b0, cfg_model.window_end} - 33'd1) & ~33'hf;
        pick = $urandom_range(0, 9);
        if (cfg_model.window_end == 32'd0 || lo > hi) begin
            h.load_base = cfg_model.window_start;
        end else if (pick == 0) begin
            h.load_base = lo[31:0];
        end else if (pick == 1) begin
            h.load_base = hi[31:0];
        end else if (pick < 5 && stored_n > 0) begin
            // land around a stored region to hit the overlap edges
            idx = $urandom_range(0, stored_n - 1);
            h.load_base = stored_base[idx] + $urandom_range(0, stored_len[idx] + 32'h40)
                          - 32'h20;
        end else begin
            h.load_base = $urandom_range(hi[31:0], lo[31:0]);
        end
        h.load_base = h.load_base & ~32'hf;
        room = (h.load_base < cfg_model.window_end) ? cfg_model.window_end - h.load_base : 32'd0;
        cap = (room < 32'h800) ? room : 32'h800;
        if (room < 32'd4 || $urandom_range(0, 9) == 0) begin
            h.footprint_bytes = room;
        end else begin
            h.footprint_bytes = $urandom_range(cap, 4);
        end
        if (h.footprint_bytes < 32'd4) begin
            h.image_bytes = 32'd4;
        end else if ($urandom_range(0, 3) == 0) begin
            h.image_bytes = h.footprint_bytes & ~32'h3;
        end else begin
            h.image_bytes = 32'($urandom_range(h.footprint_bytes >> 2, 1)) << 2;
        end
        h.init_entry_offset = entry_offset(h.image_bytes);
        h.update_entry_offset = entry_offset(h.image_bytes);
        return h;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll >= 90) begin
            r.hdr = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            r.image_ok = 1'($urandom_range(0, 1));
            return r;
        end
        r.hdr = shaped_header();
        if (roll >= 70) begin
            case ($urandom_range(0, 11))
                0: r.hdr.hdr_magic ^= 32'd1 << $urandom_range(0, 31);
                1: r.hdr.hdr_version ^= 32'd1 << $urandom_range(0, 31);
                2: r.hdr.hdr_region = $urandom | 32'd1;
                3: r.hdr.load_base |= 32'd1 << $urandom_range(0, 3);
                4: r.hdr.load_base = cfg_model.window_end;
                5: r.hdr.load_base = cfg_model.window_start - 32'd16;
                6: r.hdr.image_bytes = 32'd0;
                7: r.hdr.image_bytes |= 32'($urandom_range(1, 3));
                8: r.hdr.image_bytes = r.hdr.footprint_bytes + 32'd4;
                9: r.hdr.footprint_bytes = cfg_model.window_end - r.hdr.load_base
                                           + $urandom_range(1, 64);
                10: r.hdr.init_entry_offset = r.hdr.image_bytes;
                default: r.hdr.update_entry_offset = r.hdr.image_bytes | 32'd2;
            endcase
        end
        // admissions are kept rare so the table stays open for most of the run
        r.image_ok = stored_n < 6 && r.hdr.footprint_bytes <= 32'h800 &&
                     $urandom_range(0, 99) == 0;
        return r;
    endfunction

    function automatic mrac_pkg::t_cfg random_setting(int unsigned k);
        mrac_pkg::t_cfg c;
        c.expected_magic = $urandom;
        c.expected_version = $urandom;
        c.expected_region = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        c.no_entry_marker = $urandom_range(0, 1) ? 32'($urandom_range(0, 63)) << 2 : $urandom;
        c.window_start = ($urandom & 32'hefff_f000) | $urandom_range(0, 15);
        c.window_end = c.window_start + $urandom_range(32'h4_0000, 32'h100);
        case (k)
            0: begin
                c = '0;
                c.window_end = 32'hffff_ffff;
            end
            2: begin
                c.expected_magic = 32'hffff_ffff;
                c.expected_version = 32'hffff_ffff;
                c.expected_region = 32'hffff_ffff;
                c.no_entry_marker = 32'hffff_ffff;
                c.window_start = 32'hffff_0000;
                c.window_end = 32'hffff_ffff;
            end
            4: begin
                c.window_start = 32'd0;
                c.window_end = 32'h100;
            end
            default: ;
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Called at a falling edge; returns at the falling edge after the transfer.
    // valid is left high so back-to-back items need no second assignment.
    task automatic offer_header(input t_req r);
        if ($urandom_range(0, 99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < sender_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_hdr_magic <= r.hdr.hdr_magic;
        i_hdr_version <= r.hdr.hdr_version;
        i_hdr_region <= r.hdr.hdr_region;
        i_load_base <= r.hdr.load_base;
        i_image_bytes <= r.hdr.image_bytes;
        i_footprint_bytes <= r.hdr.footprint_bytes;
        i_init_entry_offset <= r.hdr.init_entry_offset;
        i_update_entry_offset <= r.hdr.update_entry_offset;
        i_image_ok <= r.image_ok;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_verdicts.push_back(admission_verdict(r));
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mrac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            mrac_pkg::CFG_EXPECTED_MAGIC:   cfg_model.expected_magic = data;
            mrac_pkg::CFG_EXPECTED_VERSION: cfg_model.expected_version = data;
            mrac_pkg::CFG_EXPECTED_REGION:  cfg_model.expected_region = data;
            mrac_pkg::CFG_NO_ENTRY_MARKER:  cfg_model.no_entry_marker = data;
            mrac_pkg::CFG_WINDOW_START:     cfg_model.window_start = data;
            mrac_pkg::CFG_WINDOW_END:       cfg_model.window_end = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input mrac_pkg::t_cfg c);
        write_reg(mrac_pkg::CFG_EXPECTED_MAGIC, c.expected_magic);
        write_reg(mrac_pkg::CFG_EXPECTED_VERSION, c.expected_version);
        write_reg(mrac_pkg::CFG_EXPECTED_REGION, c.expected_region);
        write_reg(mrac_pkg::CFG_NO_ENTRY_MARKER, c.no_entry_marker);
        write_reg(mrac_pkg::CFG_WINDOW_START, c.window_start);
        write_reg(mrac_pkg::CFG_WINDOW_END, c.window_end);
    endtask

    // result side: random stall, plus a counted hold-off when requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                recv_hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    initial begin
        t_verdict want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result status %0d slot %0d entries %0d",
                             $time, o_status, o_slot, o_entries_used);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        mismatches++;
                    end
                    if (o_slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d",
                                 $time, want.slot, o_slot);
                        mismatches++;
                    end
                    if (o_entries_used !== want.entries_used) begin
                        $display("%0t: entries_used expected %0d actual %0d",
                                 $time, want.entries_used, o_entries_used);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results outstanding", $time, pending_verdicts.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Registers still at reset values: zero magic/version/marker, default window.
    task automatic test_reset_defaults();
        t_req r;
        r.hdr = '0;
        r.hdr.load_base = mrac_pkg::WINDOW_START_RST;
        r.hdr.image_bytes = 32'h100;
        r.hdr.footprint_bytes = 32'h100;
        r.image_ok = 1'b0;
        offer_header(r);
        r.image_ok = 1'b1;
        offer_header(r);
        offer_header(r);
        settle();
    endtask

    task automatic test_header_rules();
        t_req g, r;
        mrac_pkg::t_cfg c;
        c.expected_magic = 32'hffff_ffff;
        c.expected_version = 32'hffff_ffff;
        c.expected_region = 32'hffff_ffff;
        c.no_entry_marker = 32'hffff_ffff;
        c.window_start = 32'h1000;
        c.window_end = 32'h9000;
        program_regs(c);
        write_reg(CFG_SPARE_LO, 32'h1234_5678);
        write_reg(CFG_SPARE_HI, 32'h0);

        g.hdr.hdr_magic = 32'hffff_ffff;
        g.hdr.hdr_version = 32'hffff_ffff;
        g.hdr.hdr_region = 32'hffff_ffff;
        g.hdr.load_base = 32'h2000;
        g.hdr.image_bytes = 32'h40;
        g.hdr.footprint_bytes = 32'h80;
        g.hdr.init_entry_offset = 32'h3c;
        g.hdr.update_entry_offset = 32'hffff_ffff;
        g.image_ok = 1'b0;

        r = g; offer_header(r);
        r = g; r.hdr.hdr_region = 32'd0; offer_header(r);
        r = g; r.hdr.hdr_region = 32'd5; offer_header(r);
        r = g; r.hdr.hdr_magic ^= 32'd1; offer_header(r);
        r = g; r.hdr.hdr_version = 32'h7fff_ffff; offer_header(r);
        r = g; r.hdr.load_base = 32'h2008; offer_header(r);
        r = g; r.hdr.load_base = 32'h0ff0; offer_header(r);
        r = g; r.hdr.load_base = 32'h9000; offer_header(r);
        // last aligned slot in the window, exactly filling it
        r = g; r.hdr.load_base = 32'h8ff0; r.hdr.image_bytes = 32'h10;
        r.hdr.footprint_bytes = 32'h10; r.hdr.init_entry_offset = 32'hc; offer_header(r);
        r = g; r.hdr.image_bytes = 32'd0; offer_header(r);
        r = g; r.hdr.image_bytes = 32'h42; offer_header(r);
        r = g; r.hdr.image_bytes = 32'h84; offer_header(r);
        r = g; r.hdr.load_base = 32'h8f80; r.hdr.footprint_bytes = 32'h81; offer_header(r);
        r = g; r.hdr.load_base = 32'h8f80; offer_header(r);
        r = g; r.hdr.init_entry_offset = 32'h40; offer_header(r);
        r = g; r.hdr.init_entry_offset = 32'h3e; offer_header(r);
        r = g; r.hdr.update_entry_offset = 32'd0; offer_header(r);
        r = g; r.hdr.update_entry_offset = 32'h44; offer_header(r);
        r = g; r.image_ok = 1'b1; offer_header(r);
        // overlap inside the stored span, then both touching neighbors
        r = g; r.hdr.load_base = 32'h2040; offer_header(r);
        r = g; r.hdr.load_base = 32'h2080; offer_header(r);
        r = g; r.hdr.load_base = 32'h1fc0; r.hdr.footprint_bytes = 32'h40; offer_header(r);
        settle();

        write_reg(mrac_pkg::CFG_WINDOW_START, 32'h9000);
        write_reg(mrac_pkg::CFG_WINDOW_END, 32'h1000);
        r = g; offer_header(r);
        settle();
    endtask

    // Results are held back long enough for the block to stall its input.
    task automatic test_backpressure();
        t_req r;
        mrac_pkg::t_cfg c;
        c = cfg_model;
        c.window_start = 32'h4000;
        c.window_end = 32'h8000;
        program_regs(c);
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        recv_hold_cycles = 80;
        repeat (8) begin
            r.hdr = shaped_header();
            r.image_ok = 1'b0;
            offer_header(r);
        end
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned gap_pct [3];
        int unsigned stall_pct [3];
        gap_pct = '{15, 72, 0};
        stall_pct = '{72, 15, 0};
        for (int p = 0; p < 3; p++) begin
            sender_gap_pct = gap_pct[p];
            receiver_stall_pct = stall_pct[p];
            for (int s = 0; s < 2; s++) begin
                settle();
                program_regs(random_setting(p * 2 + s));
                repeat (ITEMS_PER_SETTING) offer_header(random_request());
            end
        end
        settle();
    endtask

    task automatic test_table_full();
        t_req r;
        mrac_pkg::t_cfg c;
        c = cfg_model;
        c.window_start = 32'd0;
        c.window_end = 32'hffff_ffff;
        program_regs(c);
        for (int k = 0; k < 16 && stored_n < MAX_REGIONS; k++) begin
            r.hdr.hdr_magic = c.expected_magic;
            r.hdr.hdr_version = c.expected_version;
            r.hdr.hdr_region = 32'd0;
            r.hdr.load_base = (32'(k) << 28) | 32'h100;
            r.hdr.image_bytes = 32'h40;
            r.hdr.footprint_bytes = 32'h40;
            r.hdr.init_entry_offset = c.no_entry_marker;
            r.hdr.update_entry_offset = c.no_entry_marker;
            r.image_ok = 1'b1;
            offer_header(r);
        end
        repeat (6) offer_header(random_request());
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_hdr_magic = '0;
        i_hdr_version = '0;
        i_hdr_region = '0;
        i_load_base = '0;
        i_image_bytes = '0;
        i_footprint_bytes = '0;
        i_init_entry_offset = '0;
        i_update_entry_offset = '0;
        i_image_ok = 1'b0;
        cfg_model = '0;
        cfg_model.window_start = mrac_pkg::WINDOW_START_RST;
        cfg_model.window_end = mrac_pkg::WINDOW_END_RST;
        stored_n = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_header_rules();
        test_backpressure();
        test_random_traffic();
        test_table_full();

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0t: %0d mismatches, %0d results never seen",
                     $time, mismatches, pending_verdicts.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
